// ===== hdl/cpra_pkg.sv =====
`default_nettype none
// ============================================================================
// cpra_pkg
// Shared types and constants of the contiguous page run allocator: field
// widths, register indexes, status codes, controller states and the command
// and status groups between controller and datapath.
// ============================================================================
package cpra_pkg;

    localparam int PAGE_BYTES     = 4096;
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int DEF_HEAP_PAGES = 4096;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 32;
    localparam int RUN_W      = 13;
    localparam int FRAME_W    = 21;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int WANT_W     = ADDR_W - PAGE_SHIFT + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_AREA_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_AREA_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FIT_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_POOL_SIZE  = 3'd4;

    localparam logic [SIZE_W-1:0] SMALL_LIMIT_RST = 32'd2048;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK          = 3'd0,
        STS_HANDOFF     = 3'd1,
        STS_NO_SPACE    = 3'd2,
        STS_NO_STRATEGY = 3'd3,
        STS_BAD_ADDRESS = 3'd4,
        STS_UNMAPPED    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_MARK,
        S_LOOKUP,
        S_RELEASE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic check;
        logic search;
        logic mark;
        logic lookup;
        logic rel;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic chk_search;
        logic chk_lookup;
        logic found;
        logic exhausted;
        logic mark_last;
        logic lookup_used;
        logic rel_done;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/contiguous_page_run_allocator.sv =====
`default_nettype none
// Flow, accept to result valid: the checks end the word on handoff, strategy, too few frames
// or bad address; a free goes on to a page lookup (ending there if unmapped), then releases
// the stored run length clipped at the map end; an allocate scans pages until the first
// fitting run (or the map end) and marks its pages. Throughput: one word at a time; the next
// word is taken once the result is registered. Reset: synchronous; a clearing pass sweeps
// the used-page map with s_ready low, config writes taken throughout.
// ============================================================================
// contiguous_page_run_allocator
// First-fit contiguous page run allocator with a page map, run-length store
// and free frame accounting.
// ============================================================================
module contiguous_page_run_allocator #(
    parameter int HEAP_PAGES = cpra_pkg::DEF_HEAP_PAGES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [cpra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cpra_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_kind,
    input  wire logic [cpra_pkg::SIZE_W-1:0]     s_request_bytes,
    input  wire logic [cpra_pkg::ADDR_W-1:0]     s_free_address,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [cpra_pkg::STATUS_W-1:0]   m_status,
    output logic      [cpra_pkg::ADDR_W-1:0]     m_run_address,
    output logic      [cpra_pkg::RUN_W-1:0]      m_run_pages
);
    import cpra_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    cpra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cpra_dp #(
        .HEAP_PAGES (HEAP_PAGES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_kind          (s_kind),
        .s_request_bytes (s_request_bytes),
        .s_free_address  (s_free_address),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_status        (m_status),
        .m_run_address   (m_run_address),
        .m_run_pages     (m_run_pages),
        .cmd             (cmd),
        .sts             (sts)
    );

endmodule
`default_nettype wire

// ===== hdl/cpra_ram.sv =====
`default_nettype none
// ============================================================================
// cpra_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
module cpra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/cpra_ctrl.sv =====
`default_nettype none
// ============================================================================
// cpra_ctrl
// Controller of the page run allocator: sequences the clearing pass, the
// request checks, the first-fit scan, run marking, run release and result
// hand-off.
// ============================================================================
module cpra_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cpra_pkg::dp_sts_t sts,
    output cpra_pkg::dp_cmd_t      cmd
);
    import cpra_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (sts.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_CHECK;
            end
            S_CHECK: begin
                if (sts.chk_search) begin
                    state_next = S_SEARCH;
                end else if (sts.chk_lookup) begin
                    state_next = S_LOOKUP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SEARCH: begin
                if (sts.found) begin
                    state_next = S_MARK;
                end else if (sts.exhausted) begin
                    state_next = S_DONE;
                end
            end
            S_MARK: begin
                if (sts.mark_last) state_next = S_DONE;
            end
            S_LOOKUP: begin
                state_next = sts.lookup_used ? S_RELEASE : S_DONE;
            end
            S_RELEASE: begin
                if (sts.rel_done) state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR:   cmd.clear = 1'b1;
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_CHECK:   cmd.check  = 1'b1;
            S_SEARCH:  cmd.search = 1'b1;
            S_MARK:    cmd.mark   = 1'b1;
            S_LOOKUP:  cmd.lookup = 1'b1;
            S_RELEASE: cmd.rel    = 1'b1;
            S_DONE:    cmd.emit   = sts.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/cpra_dp.sv =====
`default_nettype none
// ============================================================================
// cpra_dp
// Datapath of the page run allocator: configuration registers, frame count,
// used-page map and run-length store, scan counters and the result register.
// ============================================================================
module cpra_dp #(
    parameter int HEAP_PAGES = cpra_pkg::DEF_HEAP_PAGES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [cpra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cpra_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_kind,
    input  wire logic [cpra_pkg::SIZE_W-1:0]     s_request_bytes,
    input  wire logic [cpra_pkg::ADDR_W-1:0]     s_free_address,
    input  wire logic                            m_ready,
    output logic                                 m_valid,
    output logic      [cpra_pkg::STATUS_W-1:0]   m_status,
    output logic      [cpra_pkg::ADDR_W-1:0]     m_run_address,
    output logic      [cpra_pkg::RUN_W-1:0]      m_run_pages,
    input  wire cpra_pkg::dp_cmd_t               cmd,
    output cpra_pkg::dp_sts_t                    sts
);
    import cpra_pkg::*;

    localparam int IDX_W = (HEAP_PAGES > 1) ? $clog2(HEAP_PAGES) : 1;
    localparam int CNT_W = $clog2(HEAP_PAGES + 1);
    localparam logic [CNT_W-1:0]  PAGES_CNT  = CNT_W'(HEAP_PAGES);
    localparam logic [CNT_W-1:0]  LAST_PAGE  = CNT_W'(HEAP_PAGES - 1);
    localparam logic [ADDR_W:0]   AREA_BYTES = (ADDR_W + 1)'(HEAP_PAGES) << PAGE_SHIFT;
    localparam logic [ADDR_W:0]   HEAP_WIDE  = (ADDR_W + 1)'(HEAP_PAGES);

    // configuration and frame count
    logic [ADDR_W-1:0]  block_area_start_reg, block_area_start_next;
    logic [ADDR_W-1:0]  block_area_limit_reg, block_area_limit_next;
    logic [ADDR_W-1:0]  area_base_reg, area_base_next;
    logic [SIZE_W-1:0]  small_limit_reg, small_limit_next;
    logic               first_fit_reg, first_fit_next;
    logic [FRAME_W-1:0] pool_reg, pool_next;
    logic [FRAME_W-1:0] frames_reg, frames_next;

    // request and scan
    logic               kind_reg, kind_next;
    logic [SIZE_W-1:0]  bytes_reg, bytes_next;
    logic [ADDR_W-1:0]  faddr_reg, faddr_next;
    logic [CNT_W-1:0]   want_reg, want_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   freed_reg, freed_next;
    logic [IDX_W-1:0]   first_reg, first_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;
    logic               pend_reg, pend_next;
    logic [RUN_W-1:0]   n_reg, n_next;
    logic [RUN_W-1:0]   j_reg, j_next;

    // result
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [RUN_W-1:0]   res_pages_reg, res_pages_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [ADDR_W-1:0]  m_addr_reg, m_addr_next;
    logic [RUN_W-1:0]   m_pages_reg, m_pages_next;

    // memories
    logic               pu_we;
    logic [IDX_W-1:0]   pu_waddr;
    logic               pu_wdata;
    logic [IDX_W-1:0]   rd_addr;
    logic               pu_rdata;
    logic               rl_we;
    logic [RUN_W-1:0]   rl_rdata;

    logic [WANT_W-1:0]  want_full;
    logic [FRAME_W-1:0] avail;
    logic               is_small;
    logic               no_space;
    logic               in_block;
    logic [ADDR_W-1:0]  offset;
    logic               in_area;
    logic [IDX_W-1:0]   idx_c;
    logic               can_issue;
    logic               can_rel;
    logic               found;
    logic               mark_last;
    logic               rel_done;
    logic               exhausted;
    logic               clear_last;
    logic [IDX_W-1:0]   run_first;
    logic [ADDR_W-1:0]  page_addr;
    logic [FRAME_W-1:0] frames_sub;

    cpra_ram #(
        .WIDTH (1),
        .DEPTH (HEAP_PAGES)
    ) u_page_used (
        .aclk  (aclk),
        .we    (pu_we),
        .waddr (pu_waddr),
        .wdata (pu_wdata),
        .raddr (rd_addr),
        .rdata (pu_rdata)
    );

    cpra_ram #(
        .WIDTH (RUN_W),
        .DEPTH (HEAP_PAGES)
    ) u_run_length (
        .aclk  (aclk),
        .we    (rl_we),
        .waddr (ptr_reg),
        .wdata (RUN_W'(want_reg)),
        .raddr (rd_addr),
        .rdata (rl_rdata)
    );

    assign want_full = WANT_W'(bytes_reg[ADDR_W-1:PAGE_SHIFT])
                     + WANT_W'(|bytes_reg[PAGE_SHIFT-1:0]);
    assign avail     = (pool_reg > frames_reg) ? (pool_reg - frames_reg) : '0;
    assign is_small  = (bytes_reg <= small_limit_reg);
    assign no_space  = ((ADDR_W + 1)'(want_full) > (ADDR_W + 1)'(avail))
                    || ((ADDR_W + 1)'(want_full) > HEAP_WIDE);
    assign in_block  = (faddr_reg >= block_area_start_reg) && (faddr_reg < block_area_limit_reg);
    assign offset    = faddr_reg - area_base_reg;
    assign in_area   = ({1'b0, offset} < AREA_BYTES);
    assign idx_c     = offset[PAGE_SHIFT +: IDX_W];

    assign can_issue  = (scan_reg < PAGES_CNT);
    assign can_rel    = (j_reg < n_reg) && can_issue;
    assign found      = pend_reg && !pu_rdata && ((cnt_reg + CNT_W'(1)) == want_reg);
    assign exhausted  = !pend_reg && !can_issue;
    assign mark_last  = (cnt_reg == CNT_W'(1));
    assign rel_done   = !pend_reg && !can_rel;
    assign clear_last = (scan_reg == LAST_PAGE);
    assign run_first  = (cnt_reg == '0) ? pidx_reg : first_reg;
    assign page_addr  = area_base_reg + (ADDR_W'(first_reg) << PAGE_SHIFT);
    assign frames_sub = (frames_reg >= FRAME_W'(freed_reg))
                      ? (frames_reg - FRAME_W'(freed_reg)) : '0;

    assign rd_addr  = cmd.check ? idx_c : scan_reg[IDX_W-1:0];
    assign pu_we    = cmd.clear || cmd.mark || (cmd.rel && pend_reg);
    assign pu_waddr = cmd.clear ? scan_reg[IDX_W-1:0] : (cmd.mark ? ptr_reg : pidx_reg);
    assign pu_wdata = cmd.mark;
    assign rl_we    = cmd.mark;

    always_comb begin
        sts             = '0;
        sts.clear_last  = clear_last;
        sts.chk_search  = (kind_reg == KIND_ALLOC) && !is_small && first_fit_reg && !no_space;
        sts.chk_lookup  = (kind_reg == KIND_FREE) && !in_block && in_area;
        sts.found       = found;
        sts.exhausted   = exhausted;
        sts.mark_last   = mark_last;
        sts.lookup_used = pu_rdata;
        sts.rel_done    = rel_done;
        sts.out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        block_area_start_next = block_area_start_reg;
        block_area_limit_next = block_area_limit_reg;
        area_base_next        = area_base_reg;
        small_limit_next      = small_limit_reg;
        first_fit_next        = first_fit_reg;
        pool_next             = pool_reg;
        frames_next           = frames_reg;
        kind_next             = kind_reg;
        bytes_next            = bytes_reg;
        faddr_next            = faddr_reg;
        want_next             = want_reg;
        scan_next             = scan_reg;
        cnt_next              = cnt_reg;
        freed_next            = freed_reg;
        first_next            = first_reg;
        ptr_next              = ptr_reg;
        pidx_next             = pidx_reg;
        pend_next             = pend_reg;
        n_next                = n_reg;
        j_next                = j_reg;
        res_status_next       = res_status_reg;
        res_addr_next         = res_addr_reg;
        res_pages_next        = res_pages_reg;
        m_status_next         = m_status_reg;
        m_addr_next           = m_addr_reg;
        m_pages_next          = m_pages_reg;
        m_valid_next          = m_valid_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_BLOCK_AREA_START: block_area_start_next = cfg_wdata;
                CFG_BLOCK_AREA_LIMIT: begin
                    block_area_limit_next = cfg_wdata;
                    area_base_next        = cfg_wdata + ADDR_W'(PAGE_BYTES);
                end
                CFG_SMALL_LIMIT:      small_limit_next = cfg_wdata;
                CFG_FIRST_FIT_MODE:   first_fit_next   = cfg_wdata[0];
                CFG_FRAME_POOL_SIZE:  pool_next        = cfg_wdata[FRAME_W-1:0];
                default: ;
            endcase
        end

        // sweep the used-page map after reset
        if (cmd.clear) begin
            scan_next = clear_last ? '0 : scan_reg + CNT_W'(1);
        end

        if (cmd.capture) begin
            kind_next  = s_kind;
            bytes_next = s_request_bytes;
            faddr_next = s_free_address;
        end

        if (cmd.check) begin
            pend_next      = 1'b0;
            scan_next      = '0;
            cnt_next       = '0;
            want_next      = CNT_W'(want_full);
            first_next     = idx_c;
            res_addr_next  = '0;
            res_pages_next = '0;
            res_status_next = STS_OK;
            if (kind_reg == KIND_ALLOC) begin
                if (is_small) begin
                    res_status_next = STS_HANDOFF;
                end else if (!first_fit_reg) begin
                    res_status_next = STS_NO_STRATEGY;
                end else if (no_space) begin
                    res_status_next = STS_NO_SPACE;
                end
            end else begin
                if (in_block) begin
                    res_status_next = STS_HANDOFF;
                    res_addr_next   = faddr_reg;
                end else if (!in_area) begin
                    res_status_next = STS_BAD_ADDRESS;
                end
            end
        end

        if (cmd.search) begin
            if (can_issue) begin
                scan_next = scan_reg + CNT_W'(1);
                pend_next = 1'b1;
                pidx_next = scan_reg[IDX_W-1:0];
            end else begin
                pend_next = 1'b0;
            end
            if (pend_reg) begin
                if (!pu_rdata) begin
                    if (cnt_reg == '0) first_next = pidx_reg;
                    cnt_next = cnt_reg + CNT_W'(1);
                end else begin
                    cnt_next = '0;
                end
            end
            if (found) begin
                first_next = run_first;
                ptr_next   = run_first;
                cnt_next   = want_reg;
            end else if (exhausted) begin
                res_status_next = STS_NO_SPACE;
                res_addr_next   = '0;
                res_pages_next  = '0;
            end
        end

        if (cmd.mark) begin
            ptr_next = ptr_reg + IDX_W'(1);
            cnt_next = cnt_reg - CNT_W'(1);
            if (mark_last) begin
                frames_next     = frames_reg + FRAME_W'(want_reg);
                res_status_next = STS_OK;
                res_addr_next   = page_addr;
                res_pages_next  = RUN_W'(want_reg);
            end
        end

        if (cmd.lookup) begin
            if (pu_rdata) begin
                n_next     = rl_rdata;
                scan_next  = CNT_W'(first_reg);
                j_next     = '0;
                freed_next = '0;
                pend_next  = 1'b0;
            end else begin
                res_status_next = STS_UNMAPPED;
                res_addr_next   = '0;
                res_pages_next  = '0;
            end
        end

        if (cmd.rel) begin
            if (can_rel) begin
                scan_next = scan_reg + CNT_W'(1);
                j_next    = j_reg + RUN_W'(1);
                pend_next = 1'b1;
                pidx_next = scan_reg[IDX_W-1:0];
            end else begin
                pend_next = 1'b0;
            end
            // count only pages that were in use
            if (pend_reg && pu_rdata) begin
                freed_next = freed_reg + CNT_W'(1);
            end
            if (rel_done) begin
                frames_next     = frames_sub;
                res_status_next = STS_OK;
                res_addr_next   = page_addr;
                res_pages_next  = RUN_W'(freed_reg);
            end
        end

        if (cmd.emit) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_addr_next   = res_addr_reg;
            m_pages_next  = res_pages_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_area_start_reg <= '0;
            block_area_limit_reg <= '0;
            area_base_reg        <= ADDR_W'(PAGE_BYTES);
            small_limit_reg      <= SMALL_LIMIT_RST;
            first_fit_reg        <= 1'b1;
            pool_reg             <= '0;
            frames_reg           <= '0;
            scan_reg             <= '0;
            pend_reg             <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            block_area_start_reg <= block_area_start_next;
            block_area_limit_reg <= block_area_limit_next;
            area_base_reg        <= area_base_next;
            small_limit_reg      <= small_limit_next;
            first_fit_reg        <= first_fit_next;
            pool_reg             <= pool_next;
            frames_reg           <= frames_next;
            scan_reg             <= scan_next;
            pend_reg             <= pend_next;
            m_valid_reg          <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        bytes_reg      <= bytes_next;
        faddr_reg      <= faddr_next;
        want_reg       <= want_next;
        cnt_reg        <= cnt_next;
        freed_reg      <= freed_next;
        first_reg      <= first_next;
        ptr_reg        <= ptr_next;
        pidx_reg       <= pidx_next;
        n_reg          <= n_next;
        j_reg          <= j_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_pages_reg  <= res_pages_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_pages_reg    <= m_pages_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_run_address = m_addr_reg;
    assign m_run_pages   = m_pages_reg;

endmodule
`default_nettype wire

// ===== tb/sv/contiguous_page_run_allocator_test.sv =====
`timescale 1ns / 100ps
// ============================================================================
// contiguous_page_run_allocator_test
// Self-checking bench for the first-fit page run allocator. A directed table
// covers the field extremes, every status code and the release corner cases.
// Three random phases with fresh register settings and varying idle rates on
// both sides follow. Each result word is compared against a directed row's
// fixed word or else a page map model: used pages, run lengths, frames in use.
// ============================================================================
module contiguous_page_run_allocator_test;

    import cpra_pkg::*;

    localparam int HEAP       = DEF_HEAP_PAGES;
    localparam int IDLE_LIMIT = 50000;
    localparam int WORDS      = 38;

    typedef struct packed {
        status_t              status;
        logic [ADDR_W-1:0]    run_address;
        logic [RUN_W-1:0]     run_pages;
    } page_result_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        logic                  kind;
        logic [SIZE_W-1:0]     bytes;
        logic [ADDR_W-1:0]     addr;
        logic                  fixed;
        page_result_t          exp;
    } step_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [SIZE_W-1:0]     s_request_bytes;
    logic [ADDR_W-1:0]     s_free_address;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [ADDR_W-1:0]     m_run_address;
    logic [RUN_W-1:0]      m_run_pages;

    logic                  word_fixed;
    page_result_t          word_exp;

    // model state and register copies
    bit                    page_taken [HEAP];
    logic [RUN_W-1:0]      page_run   [HEAP];
    logic [FRAME_W-1:0]    frames_used;
    logic [31:0]           cfg_start;
    logic [31:0]           cfg_limit;
    logic [31:0]           cfg_small;
    logic                  cfg_first_fit;
    logic [FRAME_W-1:0]    cfg_pool;

    page_result_t          pending_results [$];
    int                    live_runs [$];
    step_t                 script [$];
    page_result_t          predicted;
    page_result_t          observed;

    int                    mismatch_count = 0;
    int                    idle_cycles = 0;
    int                    send_idle = 0;
    int                    recv_idle = 0;
    int                    hold_left = 0;
    bit                    hold_req = 1'b0;
    bit                    hold_taken = 1'b0;

    contiguous_page_run_allocator i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_request_bytes (s_request_bytes),
        .s_free_address  (s_free_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_run_address   (m_run_address),
        .m_run_pages     (m_run_pages)
    );

    always #10 aclk = ~aclk;

    task automatic compute_page_result(input logic kind, input logic [31:0] bytes,
                                       input logic [31:0] addr, output page_result_t r);
        logic [31:0]        base;
        logic [31:0]        off;
        logic [32:0]        want;
        logic [FRAME_W-1:0] avail;
        int                 cnt;
        int                 first;
        int                 idx;
        int                 freed;
        int                 n;
        bit                 found;
        base  = cfg_limit + 32'(PAGE_BYTES);
        r     = '0;
        cnt   = 0;
        first = 0;
        freed = 0;
        found = 1'b0;
        if (kind == KIND_ALLOC) begin
            if (bytes <= cfg_small) begin
                r.status = STS_HANDOFF;
            end else if (!cfg_first_fit) begin
                r.status = STS_NO_STRATEGY;
            end else begin
                want  = ({1'b0, bytes} + 33'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
                avail = (cfg_pool > frames_used) ? cfg_pool - frames_used : '0;
                if (want > 33'(avail) || want > 33'(HEAP)) begin
                    r.status = STS_NO_SPACE;
                end else begin
                    for (int i = 0; i < HEAP && !found; i++) begin
                        if (!page_taken[i]) begin
                            if (cnt == 0) first = i;
                            cnt++;
                            if (33'(cnt) == want) found = 1'b1;
                        end else begin
                            cnt = 0;
                        end
                    end
                    if (!found) begin
                        r.status = STS_NO_SPACE;
                    end else begin
                        for (int i = first; i < first + int'(want); i++) begin
                            page_taken[i] = 1'b1;
                            page_run[i]   = want[RUN_W-1:0];
                        end
                        frames_used   = frames_used + want[FRAME_W-1:0];
                        r.status      = STS_OK;
                        r.run_address = base + 32'(first) * 32'(PAGE_BYTES);
                        r.run_pages   = want[RUN_W-1:0];
                        live_runs.push_back(first);
                    end
                end
            end
        end else if (addr >= cfg_start && addr < cfg_limit) begin
            r.status      = STS_HANDOFF;
            r.run_address = addr;
        end else begin
            off = addr - base;
            if (off >= 32'(HEAP) * 32'(PAGE_BYTES)) begin
                r.status = STS_BAD_ADDRESS;
            end else begin
                idx = int'(off >> PAGE_SHIFT);
                if (!page_taken[idx]) begin
                    r.status = STS_UNMAPPED;
                end else begin
                    n = int'(page_run[idx]);
                    for (int j = 0; j < n && idx + j < HEAP; j++) begin
                        if (page_taken[idx + j]) begin
                            page_taken[idx + j] = 1'b0;
                            page_run[idx + j]   = '0;
                            freed++;
                        end
                    end
                    frames_used   = (frames_used >= FRAME_W'(freed)) ?
                                    frames_used - FRAME_W'(freed) : '0;
                    r.status      = STS_OK;
                    r.run_address = base + 32'(idx) * 32'(PAGE_BYTES);
                    r.run_pages   = RUN_W'(freed);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BLOCK_AREA_START: cfg_start     = cfg_wdata;
                    CFG_BLOCK_AREA_LIMIT: cfg_limit     = cfg_wdata;
                    CFG_SMALL_LIMIT:      cfg_small     = cfg_wdata;
                    CFG_FIRST_FIT_MODE:   cfg_first_fit = cfg_wdata[0];
                    CFG_FRAME_POOL_SIZE:  cfg_pool      = cfg_wdata[FRAME_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                compute_page_result(s_kind, s_request_bytes, s_free_address, predicted);
                pending_results.push_back(word_fixed ? word_exp : predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result word with none pending: status %0d addr %h pages %0d",
                             $time, m_status, m_run_address, m_run_pages);
                end else begin
                    observed = pending_results.pop_front();
                    if (m_status !== observed.status || m_run_address !== observed.run_address
                        || m_run_pages !== observed.run_pages) begin
                        mismatch_count++;
                        $display("%0t: expected status %0d addr %h pages %0d, actual %0d %h %0d",
                                 $time, observed.status, observed.run_address,
                                 observed.run_pages, m_status, m_run_address, m_run_pages);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 400;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic send_word(input logic kind, input logic [31:0] bytes,
                             input logic [31:0] addr, input logic fixed,
                             input page_result_t exp);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_request_bytes <= bytes;
        s_free_address  <= addr;
        word_fixed      <= fixed;
        word_exp        <= exp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        step_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        script.push_back(row);
    endtask

    task automatic add_word(input logic kind, input logic [31:0] bytes,
                            input logic [31:0] addr, input logic fixed, input status_t st,
                            input logic [31:0] ra, input logic [RUN_W-1:0] rp);
        step_t row;
        row                 = '0;
        row.kind            = kind;
        row.bytes           = bytes;
        row.addr            = addr;
        row.fixed           = fixed;
        row.exp.status      = st;
        row.exp.run_address = ra;
        row.exp.run_pages   = rp;
        script.push_back(row);
    endtask

    initial begin : stimulus
        int          r;
        int          k;
        int          pages;
        int          idx;
        logic [31:0] addr;
        logic [31:0] bytes;
        logic [31:0] lim;

        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_kind          = KIND_ALLOC;
        s_request_bytes = '0;
        s_free_address  = '0;
        m_ready         = 1'b0;
        word_fixed      = 1'b0;
        word_exp        = '0;
        frames_used     = '0;
        cfg_start       = '0;
        cfg_limit       = '0;
        cfg_small       = SMALL_LIMIT_RST;
        cfg_first_fit   = 1'b1;
        cfg_pool        = '0;

        // reset settings: page area at 0x1000, no frames
        add_word(KIND_ALLOC, 32'd0, 32'h0, 1, STS_HANDOFF, 32'h0, 0);
        add_word(KIND_ALLOC, 32'd2048, 32'h0, 1, STS_HANDOFF, 32'h0, 0);
        add_word(KIND_ALLOC, 32'd2049, 32'h0, 1, STS_NO_SPACE, 32'h0, 0);
        add_word(KIND_FREE, 32'd0, 32'h0, 1, STS_BAD_ADDRESS, 32'h0, 0);
        add_word(KIND_FREE, 32'd0, 32'h1000, 1, STS_UNMAPPED, 32'h0, 0);
        add_word(KIND_FREE, 32'd0, 32'hFFFF_FFFF, 1, STS_BAD_ADDRESS, 32'h0, 0);
        add_write(CFG_FRAME_POOL_SIZE, 32'h0010_0000);
        add_word(KIND_ALLOC, 32'd2049, 32'h0, 1, STS_OK, 32'h1000, 1);
        add_word(KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 1, STS_NO_SPACE, 32'h0, 0);
        add_word(KIND_ALLOC, 32'h0100_0000, 32'h0, 1, STS_NO_SPACE, 32'h0, 0);
        add_word(KIND_ALLOC, 32'd12289, 32'h0, 1, STS_OK, 32'h2000, 4);
        add_word(KIND_FREE, 32'd0, 32'h2064, 1, STS_OK, 32'h2000, 4);
        add_word(KIND_FREE, 32'd0, 32'h1000, 1, STS_OK, 32'h1000, 1);
        add_word(KIND_ALLOC, 32'h0100_0000, 32'h0, 1, STS_OK, 32'h1000, 4096);
        add_word(KIND_ALLOC, 32'd4097, 32'h0, 1, STS_NO_SPACE, 32'h0, 0);
        add_word(KIND_FREE, 32'd0, 32'h0100_0005, 0, STS_OK, 32'h0, 0);
        add_word(KIND_FREE, 32'd0, 32'h1000, 0, STS_OK, 32'h0, 0);
        add_write(CFG_FIRST_FIT_MODE, 32'd0);
        add_word(KIND_ALLOC, 32'd8192, 32'h0, 1, STS_NO_STRATEGY, 32'h0, 0);
        add_word(KIND_ALLOC, 32'd100, 32'h0, 1, STS_HANDOFF, 32'h0, 0);
        add_write(CFG_FIRST_FIT_MODE, 32'd1);
        add_write(CFG_BLOCK_AREA_START, 32'h0000_1000);
        add_write(CFG_BLOCK_AREA_LIMIT, 32'hFFFF_F000);
        add_word(KIND_FREE, 32'd0, 32'h2000, 1, STS_HANDOFF, 32'h2000, 0);
        add_word(KIND_ALLOC, 32'd8192, 32'h0, 1, STS_OK, 32'h0, 2);
        add_word(KIND_FREE, 32'd0, 32'h800, 1, STS_OK, 32'h0, 2);
        add_word(KIND_FREE, 32'd0, 32'hFFFF_F000, 1, STS_BAD_ADDRESS, 32'h0, 0);
        add_write(CFG_SMALL_LIMIT, 32'hFFFF_FFFF);
        add_word(KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 1, STS_HANDOFF, 32'h0, 0);
        // page area wraps through zero
        add_write(CFG_SMALL_LIMIT, 32'd0);
        add_write(CFG_BLOCK_AREA_LIMIT, 32'hFFFF_E000);
        add_word(KIND_ALLOC, 32'd1, 32'h0, 1, STS_OK, 32'hFFFF_F000, 1);
        add_word(KIND_ALLOC, 32'd4097, 32'h0, 0, STS_OK, 32'h0, 0);
        add_word(KIND_FREE, 32'd0, 32'h10, 0, STS_OK, 32'h0, 0);
        add_word(KIND_FREE, 32'd0, 32'hFFFF_F000, 1, STS_OK, 32'hFFFF_F000, 1);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle = 13;
        recv_idle = 48;
        foreach (script[n]) begin
            if (script[n].is_cfg) begin
                drain_results();
                cfg_write(script[n].cfg_idx, script[n].cfg_val);
            end else begin
                send_word(script[n].kind, script[n].bytes, script[n].addr,
                          script[n].fixed, script[n].exp);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            drain_results();
            lim = $urandom;
            case (phase)
                0: begin
                    send_idle = 13;
                    recv_idle = 48;
                    cfg_write(CFG_BLOCK_AREA_LIMIT, lim);
                    cfg_write(CFG_BLOCK_AREA_START, lim - $urandom_range(0, 32'h0010_0000));
                    cfg_write(CFG_SMALL_LIMIT, $urandom_range(0, 8192));
                    cfg_write(CFG_FRAME_POOL_SIZE, 32'h0010_0000);
                end
                1: begin
                    send_idle = 48;
                    recv_idle = 13;
                    cfg_write(CFG_BLOCK_AREA_LIMIT, lim);
                    cfg_write(CFG_BLOCK_AREA_START, $urandom);
                    cfg_write(CFG_SMALL_LIMIT, $urandom_range(0, 4096));
                    cfg_write(CFG_FRAME_POOL_SIZE, $urandom_range(0, 64));
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                    cfg_write(CFG_BLOCK_AREA_LIMIT, 32'hFFFF_FFFF);
                    cfg_write(CFG_BLOCK_AREA_START, 32'hFFFF_FFFF);
                    cfg_write(CFG_SMALL_LIMIT, 32'd0);
                    cfg_write(CFG_FRAME_POOL_SIZE, 32'h0010_0000);
                end
            endcase
            for (int w = 0; w < WORDS; w++) begin
                if (phase == 0 && w == 10) hold_req = 1'b1;
                r     = $urandom_range(0, 99);
                bytes = $urandom;
                addr  = $urandom;
                if (r < 45) begin
                    pages = ($urandom_range(0, 99) < 3) ? $urandom_range(1, 1024)
                                                        : $urandom_range(1, 12);
                    bytes = 32'(pages - 1) * 32'(PAGE_BYTES) + $urandom_range(1, PAGE_BYTES);
                    send_word(KIND_ALLOC, bytes, addr, 1'b0, '0);
                end else if (r < 80 && live_runs.size() != 0) begin
                    k   = $urandom_range(0, live_runs.size() - 1);
                    idx = live_runs[k];
                    live_runs.delete(k);
                    if ($urandom_range(0, 3) == 0) idx = idx + $urandom_range(0, 2);
                    addr = cfg_limit + 32'(PAGE_BYTES) + 32'(idx) * 32'(PAGE_BYTES)
                           + $urandom_range(0, PAGE_BYTES - 1);
                    send_word(KIND_FREE, bytes, addr, 1'b0, '0);
                end else if (r < 88) begin
                    send_word(KIND_ALLOC, $urandom_range(0, 2048), addr, 1'b0, '0);
                end else if (r < 94) begin
                    send_word(KIND_ALLOC, bytes, addr, 1'b0, '0);
                end else if (r < 97) begin
                    send_word(KIND_FREE, bytes, cfg_start + $urandom_range(0, 4096), 1'b0, '0);
                end else begin
                    send_word(KIND_FREE, bytes, addr, 1'b0, '0);
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
